// ----- hdl/bezier_point_evaluator_top_macros.svh -----
// Assertion macros for the Bezier point evaluator.
// Included by bezier_point_evaluator_top.sv; no other dependencies.
`ifndef BEZIER_POINT_EVALUATOR_TOP_MACROS_SVH
`define BEZIER_POINT_EVALUATOR_TOP_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define BPE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define BPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bpe_pkg.sv -----
// Shared types and constants of the Bezier point evaluator.
// No dependencies; imported by bezier_point_evaluator_top and tb_top.
package bpe_pkg;

  // Curve degree select carried with each word
  typedef enum logic {
    DEG_QUAD  = 1'b0,
    DEG_CUBIC = 1'b1
  } degree_t;

  // Control point slots: start, first inner, second inner, end
  localparam int NUM_PTS  = 4;
  localparam int PT_START = 0;
  localparam int PT_CTRL1 = 1;
  localparam int PT_CTRL2 = 2;
  localparam int PT_END   = 3;

  // Axes
  localparam int NUM_AXES = 2;
  localparam int AX_X     = 0;
  localparam int AX_Y     = 1;

  // Register stages from input to output
  localparam int PIPE_DEPTH = 7;

endpackage

// ----- hdl/bezier_point_evaluator_top.sv -----
// Bezier point evaluator: quadratic or cubic curve point in fixed point.
// Depends on bpe_pkg and bezier_point_evaluator_top_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per curve point: the
//   degree select, t (unsigned, T_FRAC_BITS fraction bits, values above 1.0
//   clamp to 1.0) and the four control points. In quadratic mode the second
//   inner control point is ignored. The result channel (out_valid/out_ready)
//   returns point_x/point_y, rounded to nearest with ties toward +infinity.
//   Throughput is one word per cycle while out_ready is high: a seven-stage
//   pipeline (weights, partial products, adder tree, output register)
//   accepts a new word every cycle. Products are split in two halves so
//   that each multiplier takes only half of a weight times one coordinate.
//   Each stage advances when it is empty or the next stage moves, so empty
//   slots close up while the receiver stalls; with all seven stages full and
//   out_ready low, in_ready drops and nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; data registers are
//   not reset. There is no configuration and no state between words.
module bezier_point_evaluator_top #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_degree_mode,
  input  logic [T_FRAC_BITS:0]          in_t_param,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl1_x,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl1_y,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl2_x,
  input  logic signed [COORD_WIDTH-1:0] in_ctrl2_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y
);
  import bpe_pkg::*;

  // Width plan
  localparam int TW    = T_FRAC_BITS + 1;          // t and 1-t
  localparam int SQW   = 2 * TW;                   // products of two t terms
  localparam int CW3   = SQW + TW;                 // products of three t terms
  localparam int WW    = 3 * T_FRAC_BITS + 1;      // Bernstein weight
  localparam int SPLIT = (WW + 1) / 2;             // low half of a weight
  localparam int HIW   = WW - SPLIT;               // high half of a weight
  localparam int LPW   = SPLIT + 1 + COORD_WIDTH;  // low partial product
  localparam int HPW   = HIW + 1 + COORD_WIDTH;    // high partial product
  localparam int SW    = 3 * T_FRAC_BITS + COORD_WIDTH + 2;  // exact sum
  localparam int RSH   = 3 * T_FRAC_BITS;          // rounding position

  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;
  localparam logic [WW:0]   W_ONE = (WW + 1)'(1) << RSH;
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) << (RSH - 1);

  // Handshake chain
  logic [PIPE_DEPTH-1:0] v_r, v_nxt;
  logic [PIPE_DEPTH:0]   rdy;

  // Stage 1: clamped t, 1-t, points
  degree_t                       st1_mode_r, st1_mode_nxt;
  logic [TW-1:0]                 st1_t_r, st1_t_nxt;
  logic [TW-1:0]                 st1_s_r, st1_s_nxt;
  logic signed [COORD_WIDTH-1:0] st1_pt_r [NUM_AXES][NUM_PTS];
  logic signed [COORD_WIDTH-1:0] st1_pt_nxt [NUM_AXES][NUM_PTS];

  // Stage 2: squares and cross term
  degree_t                       st2_mode_r;
  logic [TW-1:0]                 st2_t_r, st2_s_r;
  logic [SQW-1:0]                st2_tt_r, st2_tt_nxt;
  logic [SQW-1:0]                st2_ss_r, st2_ss_nxt;
  logic [SQW-1:0]                st2_ts_r, st2_ts_nxt;
  logic signed [COORD_WIDTH-1:0] st2_pt_r [NUM_AXES][NUM_PTS];

  // Stage 3: Bernstein weights on the cubic scale
  logic [CW3-1:0]                c_sss, c_tss, c_tts, c_ttt;
  logic [WW-1:0]                 st3_w_r [NUM_PTS];
  logic [WW-1:0]                 st3_w_nxt [NUM_PTS];
  logic signed [COORD_WIDTH-1:0] st3_pt_r [NUM_AXES][NUM_PTS];

  // Stage 4: split partial products
  logic signed [LPW-1:0] st4_lo_r [NUM_AXES][NUM_PTS];
  logic signed [LPW-1:0] st4_lo_nxt [NUM_AXES][NUM_PTS];
  logic signed [HPW-1:0] st4_hi_r [NUM_AXES][NUM_PTS];
  logic signed [HPW-1:0] st4_hi_nxt [NUM_AXES][NUM_PTS];

  // Stage 5: full weighted points
  logic signed [SW-1:0] st5_prod_r [NUM_AXES][NUM_PTS];
  logic signed [SW-1:0] st5_prod_nxt [NUM_AXES][NUM_PTS];

  // Stage 6: pair sums, rounding half folded into the second pair
  logic signed [SW-1:0] st6_pair_r [NUM_AXES][2];
  logic signed [SW-1:0] st6_pair_nxt [NUM_AXES][2];

  // Stage 7: rounded result
  logic signed [SW-1:0]          sum_nxt [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] point_r [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] point_nxt [NUM_AXES];

  // Weight sum for checking
  logic [WW:0] w_sum_chk;

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    rdy[PIPE_DEPTH] = out_ready;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k + 1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready    = rdy[0];
  assign out_valid   = v_r[PIPE_DEPTH - 1];
  assign out_point_x = point_r[AX_X];
  assign out_point_y = point_r[AX_Y];

  // Stage 1: clamp t to one and form 1-t
  always_comb begin
    st1_mode_nxt = degree_t'(in_degree_mode);
    st1_t_nxt    = (in_t_param > T_ONE) ? T_ONE : in_t_param;
    st1_s_nxt    = T_ONE - st1_t_nxt;
    st1_pt_nxt[AX_X][PT_START] = in_start_x;
    st1_pt_nxt[AX_Y][PT_START] = in_start_y;
    st1_pt_nxt[AX_X][PT_CTRL1] = in_ctrl1_x;
    st1_pt_nxt[AX_Y][PT_CTRL1] = in_ctrl1_y;
    st1_pt_nxt[AX_X][PT_CTRL2] = in_ctrl2_x;
    st1_pt_nxt[AX_Y][PT_CTRL2] = in_ctrl2_y;
    st1_pt_nxt[AX_X][PT_END]   = in_end_x;
    st1_pt_nxt[AX_Y][PT_END]   = in_end_y;
  end

  // Stage 2: t*t, s*s, t*s
  always_comb begin
    st2_tt_nxt = SQW'(st1_t_r) * SQW'(st1_t_r);
    st2_ss_nxt = SQW'(st1_s_r) * SQW'(st1_s_r);
    st2_ts_nxt = SQW'(st1_t_r) * SQW'(st1_s_r);
  end

  // Stage 3: weights; quadratic weights scaled by one more t unit
  always_comb begin
    c_sss = CW3'(st2_ss_r) * CW3'(st2_s_r);
    c_tss = CW3'(st2_ts_r) * CW3'(st2_s_r);
    c_tts = CW3'(st2_ts_r) * CW3'(st2_t_r);
    c_ttt = CW3'(st2_tt_r) * CW3'(st2_t_r);
    if (st2_mode_r == DEG_CUBIC) begin
      st3_w_nxt[PT_START] = WW'(c_sss);
      st3_w_nxt[PT_CTRL1] = WW'(c_tss + (c_tss << 1));
      st3_w_nxt[PT_CTRL2] = WW'(c_tts + (c_tts << 1));
      st3_w_nxt[PT_END]   = WW'(c_ttt);
    end else begin
      st3_w_nxt[PT_START] = WW'(CW3'(st2_ss_r) << T_FRAC_BITS);
      st3_w_nxt[PT_CTRL1] = WW'(CW3'(st2_ts_r) << (T_FRAC_BITS + 1));
      st3_w_nxt[PT_CTRL2] = '0;
      st3_w_nxt[PT_END]   = WW'(CW3'(st2_tt_r) << T_FRAC_BITS);
    end
  end

  // Stage 4: weight halves times coordinates
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        st4_lo_nxt[a][i] = LPW'($signed({1'b0, st3_w_r[i][SPLIT-1:0]})) *
                           LPW'(st3_pt_r[a][i]);
        st4_hi_nxt[a][i] = HPW'($signed({1'b0, st3_w_r[i][WW-1:SPLIT]})) *
                           HPW'(st3_pt_r[a][i]);
      end
    end
  end

  // Stage 5: join halves into the full product
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        st5_prod_nxt[a][i] = (SW'(st4_hi_r[a][i]) <<< SPLIT) + SW'(st4_lo_r[a][i]);
      end
    end
  end

  // Stage 6: pair sums
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      st6_pair_nxt[a][0] = st5_prod_r[a][PT_START] + st5_prod_r[a][PT_CTRL1];
      st6_pair_nxt[a][1] = st5_prod_r[a][PT_CTRL2] + st5_prod_r[a][PT_END] +
                           ROUND_HALF;
    end
  end

  // Stage 7: final sum, drop fraction bits
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum_nxt[a]   = st6_pair_r[a][0] + st6_pair_r[a][1];
      point_nxt[a] = sum_nxt[a][RSH +: COORD_WIDTH];
    end
  end

  // Data registers: load each stage when it advances
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st1_mode_r <= st1_mode_nxt;
      st1_t_r    <= st1_t_nxt;
      st1_s_r    <= st1_s_nxt;
      st1_pt_r   <= st1_pt_nxt;
    end
    if (rdy[1]) begin
      st2_mode_r <= st1_mode_r;
      st2_t_r    <= st1_t_r;
      st2_s_r    <= st1_s_r;
      st2_tt_r   <= st2_tt_nxt;
      st2_ss_r   <= st2_ss_nxt;
      st2_ts_r   <= st2_ts_nxt;
      st2_pt_r   <= st1_pt_r;
    end
    if (rdy[2]) begin
      st3_w_r  <= st3_w_nxt;
      st3_pt_r <= st2_pt_r;
    end
    if (rdy[3]) begin
      st4_lo_r <= st4_lo_nxt;
      st4_hi_r <= st4_hi_nxt;
    end
    if (rdy[4]) begin
      st5_prod_r <= st5_prod_nxt;
    end
    if (rdy[5]) begin
      st6_pair_r <= st6_pair_nxt;
    end
    if (rdy[6]) begin
      point_r <= point_nxt;
    end
  end

  // Sum of the four weights, compared against one on the cubic scale
  always_comb begin
    w_sum_chk = (WW + 1)'(st3_w_r[PT_START]) + (WW + 1)'(st3_w_r[PT_CTRL1]) +
                (WW + 1)'(st3_w_r[PT_CTRL2]) + (WW + 1)'(st3_w_r[PT_END]);
  end

`include "bezier_point_evaluator_top_macros.svh"

  `BPE_ASSERT_SAME(a_t_split, clk, rst_n, v_r[0], (st1_t_r + st1_s_r) == T_ONE, "t and 1-t do not sum to one")
  `BPE_ASSERT_NEXT(a_t_clamp, clk, rst_n, in_valid && in_ready && (in_t_param >= T_ONE), st1_s_r == '0, "t at or above one not clamped")
  `BPE_ASSERT_SAME(a_weight_sum, clk, rst_n, v_r[2], w_sum_chk == W_ONE, "Bernstein weights do not sum to one")
  `BPE_ASSERT_SAME(a_full_stall, clk, rst_n, ($countones(v_r) == PIPE_DEPTH) && !out_ready, !in_ready, "input taken while pipeline full and stalled")

endmodule

// ----- test/tb_top.sv -----
// Testbench for bezier_point_evaluator_top: directed and random curve words checked
// against a behavioral Bernstein-sum predictor. Depends on bpe_pkg and the block's RTL.
module tb_top;
  import bpe_pkg::*;

  localparam int CW = 16;
  localparam int TF = 16;
  localparam logic [TF:0] T_ONE = 17'h10000;
  localparam logic signed [CW-1:0] C_MIN = -16'sd32768;
  localparam logic signed [CW-1:0] C_MAX = 16'sd32767;
  localparam int SINK_HOLD_CYCLES = 80;

  typedef struct packed {
    degree_t mode;
    logic [TF:0] t;
    logic signed [CW-1:0] sx, sy, c1x, c1y, c2x, c2y, ex, ey;
  } curve_word_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } point_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_degree_mode;
  logic [TF:0] in_t_param;
  logic signed [CW-1:0] in_start_x, in_start_y, in_ctrl1_x, in_ctrl1_y;
  logic signed [CW-1:0] in_ctrl2_x, in_ctrl2_y, in_end_x, in_end_y;
  logic out_valid;
  logic out_ready;
  logic signed [CW-1:0] out_point_x, out_point_y;

  point_t pending_points[$];
  int unsigned mismatch_count = 0;
  bit src_gaps_on = 1'b0;
  bit sink_stalls_on = 1'b0;
  bit sink_hold_req = 1'b0;

  bezier_point_evaluator_top #(
    .COORD_WIDTH(CW),
    .T_FRAC_BITS(TF)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_degree_mode(in_degree_mode),
    .in_t_param(in_t_param),
    .in_start_x(in_start_x),
    .in_start_y(in_start_y),
    .in_ctrl1_x(in_ctrl1_x),
    .in_ctrl1_y(in_ctrl1_y),
    .in_ctrl2_x(in_ctrl2_x),
    .in_ctrl2_y(in_ctrl2_y),
    .in_end_x(in_end_x),
    .in_end_y(in_end_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_point_x(out_point_x),
    .out_point_y(out_point_y)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Exact Bernstein sum for one axis, rounded half up at d*TF fraction bits
  function automatic logic signed [CW-1:0] bezier_axis_point(
    input degree_t mode, input logic [TF:0] t_raw,
    input logic signed [CW-1:0] p0, p1, p2, p3);
    logic [TF:0] tc;
    logic signed [127:0] a, b, c, d, tt, ss, one_w, half, sum;
    int unsigned sh;
    tc = (t_raw > T_ONE) ? T_ONE : t_raw;
    a = p0;
    b = p1;
    c = p2;
    d = p3;
    tt = tc;
    one_w = 1;
    one_w = one_w <<< TF;
    ss = one_w - tt;
    if (mode == DEG_CUBIC) begin
      sum = a * ss * ss * ss + 3 * b * tt * ss * ss + 3 * c * tt * tt * ss + d * tt * tt * tt;
      sh = 3 * TF;
    end else begin
      sum = a * ss * ss + 2 * b * tt * ss + d * tt * tt;
      sh = 2 * TF;
    end
    half = 1;
    half = half <<< (sh - 1);
    sum = (sum + half) >>> sh;
    return sum[CW-1:0];
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (r % 4)
      0: if (r < 10) return C_MIN;
      1: if (r < 10) return C_MAX;
      2: if (r < 10) return '0;
      default: if (r < 10) return '1;
    endcase
    return CW'($urandom());
  endfunction

  function automatic curve_word_t rand_word();
    curve_word_t w;
    int unsigned r;
    w.mode = degree_t'(1'($urandom_range(0, 1)));
    r = $urandom_range(0, 99);
    if (r < 10) w.t = (TF + 1)'($urandom());
    else if (r < 14) w.t = '0;
    else if (r < 18) w.t = T_ONE;
    else w.t = (TF + 1)'($urandom_range(0, T_ONE));
    w.sx = rand_coord();
    w.sy = rand_coord();
    w.c1x = rand_coord();
    w.c1y = rand_coord();
    w.c2x = rand_coord();
    w.c2y = rand_coord();
    w.ex = rand_coord();
    w.ey = rand_coord();
    return w;
  endfunction

  function automatic curve_word_t make_word(input degree_t mode, input logic [TF:0] t,
    input logic signed [CW-1:0] sx, sy, c1x, c1y, c2x, c2y, ex, ey);
    curve_word_t w;
    w.mode = mode;
    w.t = t;
    w.sx = sx;
    w.sy = sy;
    w.c1x = c1x;
    w.c1y = c1y;
    w.c2x = c2x;
    w.c2y = c2y;
    w.ex = ex;
    w.ey = ey;
    return w;
  endfunction

  // Offer one word, hold it until accepted, then queue its predicted point
  task automatic send_word(input curve_word_t w);
    int unsigned gap;
    point_t p;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_degree_mode <= w.mode;
    in_t_param <= w.t;
    in_start_x <= w.sx;
    in_start_y <= w.sy;
    in_ctrl1_x <= w.c1x;
    in_ctrl1_y <= w.c1y;
    in_ctrl2_x <= w.c2x;
    in_ctrl2_y <= w.c2y;
    in_end_x <= w.ex;
    in_end_y <= w.ey;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p.x = bezier_axis_point(w.mode, w.t, w.sx, w.c1x, w.c2x, w.ex);
    p.y = bezier_axis_point(w.mode, w.t, w.sy, w.c1y, w.c2y, w.ey);
    pending_points.push_back(p);
  endtask

  // Result side: random stalls, plus one long hold when requested
  initial begin : result_sink
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 99) < 30) begin
        stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : result_check
    point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected result word: point_x %0d point_y %0d", out_point_x, out_point_y);
        mismatch_count++;
      end else begin
        want = pending_points.pop_front();
        if (out_point_x !== want.x) begin
          $error("point_x mismatch: expected %0d, actual %0d", want.x, out_point_x);
          mismatch_count++;
        end
        if (out_point_y !== want.y) begin
          $error("point_y mismatch: expected %0d, actual %0d", want.y, out_point_y);
          mismatch_count++;
        end
      end
    end
  end

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // t at zero, one and above one (clamped) for both degrees, midpoint (cubic), near zero and one
  task automatic test_t_endpoints();
    send_word(make_word(DEG_QUAD, '0, 16'sd100, -16'sd200, 16'sd300, 16'sd400,
                        16'sd500, 16'sd600, -16'sd700, 16'sd800));
    send_word(make_word(DEG_QUAD, T_ONE, 16'sd100, -16'sd200, 16'sd300, 16'sd400,
                        16'sd500, 16'sd600, -16'sd700, 16'sd800));
    send_word(make_word(DEG_CUBIC, '0, -16'sd1234, 16'sd4321, 16'sd99, -16'sd99,
                        16'sd7, 16'sd8, 16'sd2000, -16'sd3000));
    send_word(make_word(DEG_CUBIC, T_ONE, -16'sd1234, 16'sd4321, 16'sd99, -16'sd99,
                        16'sd7, 16'sd8, 16'sd2000, -16'sd3000));
    send_word(make_word(DEG_CUBIC, T_ONE + 17'd1, 16'sd11, 16'sd22, 16'sd33, 16'sd44,
                        16'sd55, 16'sd66, 16'sd77, 16'sd88));
    send_word(make_word(DEG_QUAD, '1, 16'sd11, 16'sd22, 16'sd33, 16'sd44,
                        16'sd55, 16'sd66, 16'sd77, 16'sd88));
    send_word(make_word(DEG_CUBIC, 17'h08000, 16'sd256, -16'sd256, -16'sd512, 16'sd512,
                        16'sd1024, -16'sd1024, 16'sd0, 16'sd1));
    send_word(make_word(DEG_QUAD, 17'd1, C_MAX, C_MIN, C_MIN, C_MAX,
                        C_MAX, C_MAX, C_MIN, C_MIN));
    send_word(make_word(DEG_CUBIC, T_ONE - 17'd1, C_MAX, C_MIN, C_MIN, C_MAX,
                        C_MAX, C_MIN, C_MIN, C_MAX));
  endtask

  // Coordinate extremes, rounding ties on both signs, ignored second inner point
  task automatic test_coord_extremes();
    send_word(make_word(DEG_QUAD, 17'h08000, C_MAX, C_MAX, C_MAX, C_MAX,
                        C_MIN, C_MIN, C_MAX, C_MAX));
    send_word(make_word(DEG_CUBIC, 17'h08000, C_MAX, C_MAX, C_MAX, C_MAX,
                        C_MAX, C_MAX, C_MAX, C_MAX));
    send_word(make_word(DEG_QUAD, 17'h05555, C_MIN, C_MIN, C_MIN, C_MIN,
                        C_MAX, C_MAX, C_MIN, C_MIN));
    send_word(make_word(DEG_CUBIC, 17'h0AAAA, C_MIN, C_MIN, C_MIN, C_MIN,
                        C_MIN, C_MIN, C_MIN, C_MIN));
    send_word(make_word(DEG_CUBIC, 17'h08000, C_MIN, C_MAX, C_MAX, C_MIN,
                        C_MIN, C_MAX, C_MAX, C_MIN));
    send_word(make_word(DEG_QUAD, 17'h08000, 16'sd1, -16'sd1, 16'sd0, 16'sd0,
                        C_MAX, C_MIN, 16'sd1, -16'sd1));
    send_word(make_word(DEG_QUAD, 17'h08000, -16'sd1, 16'sd1, 16'sd0, 16'sd0,
                        C_MIN, C_MAX, -16'sd1, 16'sd1));
    send_word(make_word(DEG_CUBIC, 17'h08000, 16'sd0, -16'sd1, 16'sd1, 16'sd0,
                        16'sd0, 16'sd0, 16'sd1, -16'sd1));
    send_word(make_word(DEG_QUAD, 17'h04000, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                        C_MIN, C_MAX, 16'sd0, 16'sd0));
    send_word(make_word(DEG_QUAD, 17'h04000, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                        C_MAX, C_MIN, 16'sd0, 16'sd0));
  endtask

  // Back-to-back random words with the result side always ready
  task automatic test_random_stream(input int unsigned count);
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (count) send_word(rand_word());
  endtask

  // Random words with idling and stalls on both sides
  task automatic test_random_idle(input int unsigned count);
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    repeat (count) send_word(rand_word());
  endtask

  // Hold the result side off so the pipeline fills and input stalls
  task automatic test_backpressure(input int unsigned count);
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    sink_hold_req = 1'b1;
    repeat (count) send_word(rand_word());
  endtask

  initial begin
    in_valid <= 1'b0;
    in_degree_mode <= 1'b0;
    in_t_param <= '0;
    in_start_x <= '0;
    in_start_y <= '0;
    in_ctrl1_x <= '0;
    in_ctrl1_y <= '0;
    in_ctrl2_x <= '0;
    in_ctrl2_y <= '0;
    in_end_x <= '0;
    in_end_y <= '0;
    apply_reset();
    test_t_endpoints();
    test_coord_extremes();
    test_random_stream(150);
    test_random_idle(400);
    test_backpressure(40);
    test_random_idle(90);
    in_valid <= 1'b0;
    // Drain outstanding points, then watch for stray words
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH * 3) @(posedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
